// File: hw/rtl/gl5_pkg.sv
// ----------------------------------------------------------------------------
// gl5_pkg
// Shared types, constants and the XB advance table for the GPS L5 ranging
// code generator.
// ----------------------------------------------------------------------------
package gl5_pkg;

	localparam int CODE_LENGTH     = 10230;
	localparam int XA_SHORT_PERIOD = 8190;

	localparam int REG_W  = 13;
	localparam int CHIP_W = 14;
	localparam int PRN_W  = 6;
	localparam int ROW_W  = 6;
	localparam int CFG_W  = 6;

	localparam logic [REG_W-1:0]  REG_ONES   = 13'h1FFF;
	localparam logic [REG_W-1:0]  XA_TAPS    = 13'b0000000011011;
	localparam logic [REG_W-1:0]  XB_TAPS    = 13'b1011011100011;
	localparam logic [CHIP_W-1:0] CODE_LAST  = CHIP_W'(CODE_LENGTH - 1);
	localparam logic [REG_W-1:0]  XA_LAST    = REG_W'(XA_SHORT_PERIOD - 1);
	localparam logic [PRN_W-1:0]  PRN_RESET  = 6'd1;

	// configuration register indexes
	localparam logic CFG_PRN  = 1'b0;
	localparam logic CFG_QSEL = 1'b1;

	// XB advance per row: 32 in-phase entries, then 32 quadrature entries
	localparam logic [REG_W-1:0] ADV_ROM [0:63] = '{
		13'd266,  13'd365,  13'd804,  13'd1138, 13'd1509, 13'd1559, 13'd1756, 13'd2084,
		13'd2170, 13'd2303, 13'd2527, 13'd2687, 13'd2930, 13'd3471, 13'd3940, 13'd4132,
		13'd4332, 13'd4924, 13'd5343, 13'd5443, 13'd5641, 13'd5816, 13'd5898, 13'd5918,
		13'd5955, 13'd6243, 13'd6345, 13'd6477, 13'd6518, 13'd6875, 13'd7168, 13'd7187,
		13'd1701, 13'd323,  13'd5292, 13'd2020, 13'd5429, 13'd7136, 13'd1041, 13'd5947,
		13'd4315, 13'd148,  13'd535,  13'd1939, 13'd5206, 13'd5910, 13'd3595, 13'd5135,
		13'd6082, 13'd6990, 13'd3546, 13'd1523, 13'd4548, 13'd4484, 13'd1893, 13'd3961,
		13'd7106, 13'd5299, 13'd4660, 13'd276,  13'd4389, 13'd3783, 13'd1591, 13'd1601
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADVANCE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic align;
		logic adv_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_align;
		logic adv_last;
	} sts_t;

	function automatic logic [REG_W-1:0] lfsr_next(input logic [REG_W-1:0] r,
		input logic [REG_W-1:0] taps);
		return {^(r & taps), r[REG_W-1:1]};
	endfunction

endpackage

// File: hw/rtl/gl5_ctrl.sv
// ----------------------------------------------------------------------------
// gl5_ctrl
// Sequencer: accepts transactions, runs the XB advance after a re-alignment
// and owns the output valid.
// ----------------------------------------------------------------------------
module gl5_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  gl5_pkg::sts_t sts,
	output gl5_pkg::cmd_t cmd
);
	import gl5_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && slot_free);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.need_align) begin
						cmd.align = 1'b1;
						state_d   = ST_ADVANCE;
					end else begin
						cmd.emit = 1'b1;
					end
				end
			end
			ST_ADVANCE: begin
				cmd.adv_step = 1'b1;
				if (sts.adv_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> slot_free)
		else $error("result emitted over an untaken result");
	a_direct_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sts.need_align) |=> out_valid_q)
		else $error("accepted transaction produced no result");
	a_advance_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADVANCE && sts.adv_last) |=> (state_q == ST_EMIT))
		else $error("advance did not finish into emit");
`endif

endmodule

// File: hw/rtl/gl5_datapath.sv
// ----------------------------------------------------------------------------
// gl5_datapath
// XA/XB shift registers, position and chip counters, advance counter and
// the output payload register.
// ----------------------------------------------------------------------------
module gl5_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gl5_pkg::cmd_t                     cmd,
	output gl5_pkg::sts_t                     sts,
	input  logic                              restart,
	input  logic [gl5_pkg::ROW_W-1:0]         cur_row,
	output logic                              chip_negative,
	output logic [gl5_pkg::CHIP_W-1:0]        chip_index,
	output logic                              period_end
);
	import gl5_pkg::*;

	logic [REG_W-1:0]  xa_q;
	logic [REG_W-1:0]  xa_pos_q;
	logic [REG_W-1:0]  xb_q;
	logic [CHIP_W-1:0] xb_pos_q;
	logic [CHIP_W-1:0] chip_cnt_q;
	logic [REG_W-1:0]  adv_cnt_q;
	logic              aligned_q;
	logic              pending_q;
	logic [ROW_W-1:0]  pend_row_q;

	logic              use_cur;
	logic [ROW_W-1:0]  row;
	logic [REG_W-1:0]  xb_step;
	logic [CHIP_W-1:0] xb_pos_step;

	logic              out_neg_q;
	logic [CHIP_W-1:0] out_idx_q;
	logic              out_end_q;

	assign use_cur        = restart || !aligned_q;
	assign row            = use_cur ? cur_row : pend_row_q;
	assign sts.need_align = use_cur || pending_q;
	assign sts.adv_last   = (adv_cnt_q == REG_W'(1));

	always_comb begin
		if (xb_pos_q == CODE_LAST) begin
			xb_step     = REG_ONES;
			xb_pos_step = '0;
		end else begin
			xb_step     = lfsr_next(xb_q, XB_TAPS);
			xb_pos_step = xb_pos_q + CHIP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xa_q       <= REG_ONES;
			xa_pos_q   <= '0;
			xb_q       <= REG_ONES;
			xb_pos_q   <= '0;
			chip_cnt_q <= '0;
			adv_cnt_q  <= '0;
			aligned_q  <= 1'b0;
			pending_q  <= 1'b0;
			pend_row_q <= '0;
		end else if (cmd.align) begin
			xa_q       <= REG_ONES;
			xa_pos_q   <= '0;
			xb_q       <= REG_ONES;
			xb_pos_q   <= '0;
			chip_cnt_q <= '0;
			adv_cnt_q  <= ADV_ROM[row];
			aligned_q  <= 1'b1;
			pending_q  <= 1'b0;
		end else if (cmd.adv_step) begin
			xb_q      <= xb_step;
			xb_pos_q  <= xb_pos_step;
			adv_cnt_q <= adv_cnt_q - REG_W'(1);
		end else if (cmd.emit) begin
			if (chip_cnt_q == CODE_LAST) begin
				// re-align at the next transaction; unless restart is set, use the row selected now
				chip_cnt_q <= '0;
				pending_q  <= 1'b1;
				pend_row_q <= cur_row;
			end else begin
				chip_cnt_q <= chip_cnt_q + CHIP_W'(1);
				xb_q       <= xb_step;
				xb_pos_q   <= xb_pos_step;
				if (xa_pos_q == XA_LAST) begin
					xa_q     <= REG_ONES;
					xa_pos_q <= '0;
				end else begin
					xa_q     <= lfsr_next(xa_q, XA_TAPS);
					xa_pos_q <= xa_pos_q + REG_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_neg_q <= xa_q[0] ^ xb_q[0];
			out_idx_q <= chip_cnt_q;
			out_end_q <= (chip_cnt_q == CODE_LAST);
		end
	end

	assign chip_negative = out_neg_q;
	assign chip_index    = out_idx_q;
	assign period_end    = out_end_q;

`ifndef SYNTHESIS
	a_chip_range: assert property (@(posedge clk) disable iff (!arst_n)
		chip_cnt_q <= CODE_LAST)
		else $error("chip counter beyond code period");
	a_xa_range: assert property (@(posedge clk) disable iff (!arst_n)
		xa_pos_q <= XA_LAST)
		else $error("XA position beyond short period");
	a_xb_range: assert property (@(posedge clk) disable iff (!arst_n)
		xb_pos_q <= CODE_LAST)
		else $error("XB position beyond code period");
`endif

endmodule

// File: hw/rtl/gps_l5_ranging_code_generator_core.sv
// ----------------------------------------------------------------------------
// gps_l5_ranging_code_generator_core
// GPS L5 ranging code generator: one code chip per input transaction.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  restart
//  output   out_valid/out_stall  chip_negative, chip_index, period_end
//  config   cfg_we               cfg_index, cfg_data
//
//  A transaction that continues the code is emitted as it is accepted.
//  A re-alignment (restart, first transaction after reset, or first one
//  after a period end) resets XA and XB, steps XB once per cycle through
//  the advance counter, then emits the chip when the output slot is free.
//  The output register takes a result while the next input is accepted.
//  Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module gps_l5_ranging_code_generator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        restart,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        chip_negative,
	output logic [gl5_pkg::CHIP_W-1:0]  chip_index,
	output logic                        period_end,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gl5_pkg::CFG_W-1:0]   cfg_data
);
	import gl5_pkg::*;

	logic [PRN_W-1:0] prn_q;
	logic             qsel_q;
	logic [PRN_W-1:0] prn_m1;
	logic [ROW_W-1:0] cur_row;
	cmd_t             cmd;
	sts_t             sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prn_q  <= PRN_RESET;
			qsel_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRN:  prn_q  <= cfg_data[PRN_W-1:0];
				CFG_QSEL: qsel_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// PRN 0 maps to row 31, PRN 33..63 fold onto 0..30
	assign prn_m1  = prn_q - PRN_W'(1);
	assign cur_row = {qsel_q, prn_m1[4:0]};

	gl5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gl5_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.restart       (restart),
		.cur_row       (cur_row),
		.chip_negative (chip_negative),
		.chip_index    (chip_index),
		.period_end    (period_end)
	);

endmodule
